FILE: design/clb_pkg.sv
// Shared types, constants and codes for the cursor list buffer.
`default_nettype none
package clb_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = 7;
  localparam int CUR_W = 8;
  localparam int WORD_W = 32;

  localparam logic [3:0] OP_APPEND      = 4'd0;
  localparam logic [3:0] OP_INSERT_AT   = 4'd1;
  localparam logic [3:0] OP_DELETE_LAST = 4'd2;
  localparam logic [3:0] OP_DELETE_AT   = 4'd3;
  localparam logic [3:0] OP_FWD         = 4'd4;
  localparam logic [3:0] OP_BACK        = 4'd5;
  localparam logic [3:0] OP_INS_CUR     = 4'd6;
  localparam logic [3:0] OP_DEL_CUR     = 4'd7;
  localparam logic [3:0] OP_READ_CUR    = 4'd8;
  localparam logic [3:0] OP_UPD_AT      = 4'd9;
  localparam logic [3:0] OP_UPD_CUR     = 4'd10;
  localparam logic [3:0] OP_SWAP        = 4'd11;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_EMPTY = 3'd1;
  localparam logic [2:0] STAT_OOB   = 3'd2;
  localparam logic [2:0] STAT_NULL  = 3'd3;
  localparam logic [2:0] STAT_FULL  = 3'd4;

  localparam logic signed [CUR_W-1:0] CUR_NONE = -8'sd1;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INS,
    CK_DEL,
    CK_WR
  } cell_kind_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_kind_t              kind;
    logic [IDX_W-1:0]        at_a;
    logic [IDX_W-1:0]        at_b;
    logic [WORD_W-1:0]       wd_a;
    logic [WORD_W-1:0]       wd_b;
  } cell_cmd_t;

  // Decoded request: status, cell action and the new length and cursor.
  typedef struct packed {
    logic [2:0]              status;
    cell_kind_t              kind;
    logic [IDX_W-1:0]        at_a;
    logic [IDX_W-1:0]        at_b;
    logic [LEN_W-1:0]        len;
    logic signed [CUR_W-1:0] cur;
    logic                    rd;
    logic                    swap;
  } dec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_APPLY
  } state_t;

endpackage
`default_nettype wire

FILE: design/clb_cell.sv
// One storage cell of the row: holds a word, shifts to or from a neighbor, or is written.
`default_nettype none
module clb_cell (
  input  wire logic                        clk,
  input  wire logic [clb_pkg::IDX_W-1:0]   idx,
  input  wire clb_pkg::cell_cmd_t          cmd,
  input  wire logic [clb_pkg::WORD_W-1:0]  lo_word,
  input  wire logic [clb_pkg::WORD_W-1:0]  hi_word,
  output logic      [clb_pkg::WORD_W-1:0]  word
);

  logic [clb_pkg::WORD_W-1:0] word_r;
  logic [clb_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (cmd.kind)
      clb_pkg::CK_INS: begin
        if (idx > cmd.at_a) begin
          word_nxt = lo_word;
        end else if (idx == cmd.at_a) begin
          word_nxt = cmd.wd_a;
        end
      end
      clb_pkg::CK_DEL: begin
        if (idx >= cmd.at_a) begin
          word_nxt = hi_word;
        end
      end
      clb_pkg::CK_WR: begin
        if (idx == cmd.at_a) begin
          word_nxt = cmd.wd_a;
        end else if (idx == cmd.at_b) begin
          word_nxt = cmd.wd_b;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule
`default_nettype wire

FILE: design/clb_ctrl.sv
// Request decoder: status checks, cell action, new length and cursor.
`default_nettype none
module clb_ctrl (
  input  wire logic [3:0]                         op,
  input  wire logic [15:0]                        position,
  input  wire logic [clb_pkg::LEN_W-1:0]          len,
  input  wire logic signed [clb_pkg::CUR_W-1:0]   cur,
  output clb_pkg::dec_t                           dec
);

  logic                        empty;
  logic                        full;
  logic                        pos_gt_len;
  logic                        pos_ge_len;
  logic                        cur_neg;
  logic                        cur_ok;
  logic                        cur_gt_len;
  logic [clb_pkg::LEN_W-1:0]   len_m1;
  logic [clb_pkg::IDX_W-1:0]   cu;
  logic [clb_pkg::IDX_W-1:0]   pi;

  always_comb begin
    empty      = (len == '0);
    full       = (len >= clb_pkg::LEN_W'(clb_pkg::DEPTH));
    pos_gt_len = (position > {9'd0, len});
    pos_ge_len = (position >= {9'd0, len});
    cur_neg    = cur[clb_pkg::CUR_W-1];
    cur_ok     = !cur_neg && ($unsigned(cur) < {1'b0, len});
    cur_gt_len = $unsigned(cur) > {1'b0, len};
    len_m1     = len - 7'd1;
    cu         = cur[clb_pkg::IDX_W-1:0];
    pi         = position[clb_pkg::IDX_W-1:0];

    dec        = '0;
    dec.status = clb_pkg::STAT_OK;
    dec.kind   = clb_pkg::CK_HOLD;
    dec.at_a   = pi;
    dec.at_b   = pi;
    dec.len    = len;
    dec.cur    = cur;
    dec.rd     = 1'b0;
    dec.swap   = 1'b0;

    case (op)
      clb_pkg::OP_APPEND: begin
        if (full) begin
          dec.status = clb_pkg::STAT_FULL;
        end else begin
          dec.kind = clb_pkg::CK_INS;
          dec.at_a = len[clb_pkg::IDX_W-1:0];
          dec.len  = len + 7'd1;
        end
      end
      clb_pkg::OP_INSERT_AT: begin
        if (full) begin
          dec.status = clb_pkg::STAT_FULL;
        end else if (pos_gt_len) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_INS;
          dec.len  = len + 7'd1;
        end
      end
      clb_pkg::OP_DELETE_LAST: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else begin
          dec.len = len_m1;
        end
      end
      clb_pkg::OP_DELETE_AT: begin
        if (pos_ge_len) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_DEL;
          dec.len  = len_m1;
        end
      end
      clb_pkg::OP_FWD: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
          dec.cur    = clb_pkg::CUR_NONE;
        end else if (position < {9'd0, len_m1}) begin
          dec.cur = {1'b0, position[clb_pkg::LEN_W-1:0]};
        end else begin
          dec.cur = {1'b0, len_m1};
        end
      end
      clb_pkg::OP_BACK: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
          dec.cur    = clb_pkg::CUR_NONE;
        end else if (pos_gt_len) begin
          dec.status = clb_pkg::STAT_OOB;
          dec.cur    = clb_pkg::CUR_NONE;
        end else begin
          dec.cur = {1'b0, len - position[clb_pkg::LEN_W-1:0]};
        end
      end
      clb_pkg::OP_INS_CUR: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (cur_neg || cur_gt_len) begin
          dec.status = clb_pkg::STAT_OOB;
        end else if (full) begin
          dec.status = clb_pkg::STAT_FULL;
        end else begin
          dec.kind = clb_pkg::CK_INS;
          dec.at_a = cu;
          dec.len  = len + 7'd1;
        end
      end
      clb_pkg::OP_DEL_CUR: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (!cur_ok) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_DEL;
          dec.at_a = cu;
          dec.len  = len_m1;
        end
      end
      clb_pkg::OP_READ_CUR: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (!cur_ok) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.rd = 1'b1;
        end
      end
      clb_pkg::OP_UPD_AT: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (pos_ge_len) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_WR;
        end
      end
      clb_pkg::OP_UPD_CUR: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (cur_neg) begin
          dec.status = clb_pkg::STAT_NULL;
        end else if (!cur_ok) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_WR;
          dec.at_a = cu;
          dec.at_b = cu;
        end
      end
      clb_pkg::OP_SWAP: begin
        if (empty) begin
          dec.status = clb_pkg::STAT_EMPTY;
        end else if (!cur_ok || pos_ge_len) begin
          dec.status = clb_pkg::STAT_OOB;
        end else begin
          dec.kind = clb_pkg::CK_WR;
          dec.at_a = cu;
          dec.at_b = pi;
          dec.swap = 1'b1;
        end
      end
      default: begin
        dec.status = clb_pkg::STAT_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/cursor_list_buffer.sv
// Top level: request sequencer, row of storage cells and result register.
// Cursor list buffer: an editable sequence of up to 64 signed 32-bit words
// with a cursor, held in a row of cells that shift up on insert and down
// on delete, every cell from the edit position up moving in the same cycle.
// Input channel (in_valid/in_ready): one request item per handshake, with
// op, position and value. Result channel (out_valid/out_ready): exactly
// one result item per request, in order: status, read data, cursor and
// length after the request.
// Timing: an accepted item is decoded and the cursor and position words
// are gathered from the row in the next cycle; the apply step then
// updates the row and writes the result register together. The block
// takes no new item until the apply step of the last one is done, set by
// the fetch and apply steps of the sequencer around the cell row.
// A stalled receiver holds the result in the output register; the next
// item is still accepted and decoded, and waits in the apply step until
// the output register frees.
// Reset (rst_n low, synchronous) empties the buffer, sets the cursor to 0
// and drops any pending result. Cell contents are not cleared; cells at
// or beyond the length are never read.
`default_nettype none
module cursor_list_buffer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_op,
  input  wire logic [15:0]        in_position,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_read_value,
  output logic signed [7:0]       out_cursor_now,
  output logic [6:0]              out_length_now
);

  clb_pkg::state_t                   state_r;
  clb_pkg::state_t                   state_nxt;
  logic [3:0]                        op_r;
  logic [15:0]                       pos_r;
  logic [clb_pkg::WORD_W-1:0]        value_r;
  logic [clb_pkg::LEN_W-1:0]         len_r;
  logic signed [clb_pkg::CUR_W-1:0]  cur_r;
  clb_pkg::dec_t                     dec;
  clb_pkg::dec_t                     dec_r;
  logic [clb_pkg::WORD_W-1:0]        cur_word;
  logic [clb_pkg::WORD_W-1:0]        pos_word;
  logic [clb_pkg::WORD_W-1:0]        cur_word_r;
  logic [clb_pkg::WORD_W-1:0]        pos_word_r;
  logic [clb_pkg::WORD_W-1:0]        cell_word [clb_pkg::DEPTH];
  clb_pkg::cell_cmd_t                cmd;
  logic                              accept;
  logic                              fetch_en;
  logic                              apply_en;
  logic                              out_valid_r;
  logic [2:0]                        status_r;
  logic [clb_pkg::WORD_W-1:0]        rdata_r;
  logic signed [clb_pkg::CUR_W-1:0]  cur_out_r;
  logic [clb_pkg::LEN_W-1:0]         len_out_r;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clb_pkg::S_IDLE:  if (in_valid) state_nxt = clb_pkg::S_FETCH;
      clb_pkg::S_FETCH: state_nxt = clb_pkg::S_APPLY;
      clb_pkg::S_APPLY: if (!out_valid_r || out_ready) state_nxt = clb_pkg::S_IDLE;
      default:          state_nxt = clb_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    fetch_en = 1'b0;
    apply_en = 1'b0;
    case (state_r)
      clb_pkg::S_IDLE:  in_ready = 1'b1;
      clb_pkg::S_FETCH: fetch_en = 1'b1;
      clb_pkg::S_APPLY: apply_en = !out_valid_r || out_ready;
      default:          in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      pos_r   <= in_position;
      value_r <= in_value;
    end
  end

  clb_ctrl u_ctrl (
    .op       (op_r),
    .position (pos_r),
    .len      (len_r),
    .cur      (cur_r),
    .dec      (dec)
  );

  // Pick the words at the cursor and at position out of the row.
  always_comb begin
    cur_word = '0;
    pos_word = '0;
    for (int k = 0; k < clb_pkg::DEPTH; k++) begin
      if (clb_pkg::IDX_W'(k) == cur_r[clb_pkg::IDX_W-1:0]) cur_word = cur_word | cell_word[k];
      if (clb_pkg::IDX_W'(k) == pos_r[clb_pkg::IDX_W-1:0]) pos_word = pos_word | cell_word[k];
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_en) begin
      dec_r      <= dec;
      cur_word_r <= cur_word;
      pos_word_r <= pos_word;
    end
  end

  always_comb begin
    cmd.kind = apply_en ? dec_r.kind : clb_pkg::CK_HOLD;
    cmd.at_a = dec_r.at_a;
    cmd.at_b = dec_r.at_b;
    cmd.wd_a = dec_r.swap ? pos_word_r : value_r;
    cmd.wd_b = dec_r.swap ? cur_word_r : value_r;
  end

  for (genvar g = 0; g < clb_pkg::DEPTH; g++) begin : g_cell
    logic [clb_pkg::WORD_W-1:0] lo_w;
    logic [clb_pkg::WORD_W-1:0] hi_w;
    if (g == 0) begin : g_lo_edge
      assign lo_w = cell_word[g];
    end else begin : g_lo
      assign lo_w = cell_word[g-1];
    end
    if (g == clb_pkg::DEPTH - 1) begin : g_hi_edge
      assign hi_w = cell_word[g];
    end else begin : g_hi
      assign hi_w = cell_word[g+1];
    end
    clb_cell u_cell (
      .clk     (clk),
      .idx     (clb_pkg::IDX_W'(g)),
      .cmd     (cmd),
      .lo_word (lo_w),
      .hi_word (hi_w),
      .word    (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cur_r <= '0;
    end else if (apply_en) begin
      len_r <= dec_r.len;
      cur_r <= dec_r.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      status_r  <= dec_r.status;
      rdata_r   <= dec_r.rd ? cur_word_r : '0;
      cur_out_r <= dec_r.cur;
      len_out_r <= dec_r.len;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rdata_r;
  assign out_cursor_now = cur_out_r;
  assign out_length_now = len_out_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= clb_pkg::LEN_W'(clb_pkg::DEPTH))
    else $error("length beyond depth");

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == clb_pkg::S_FETCH)
    else $error("accepted item not fetched");

  a_apply_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clb_pkg::S_APPLY && out_valid_r && !out_ready) |=>
      state_r == clb_pkg::S_APPLY && $stable(len_r) && $stable(cur_r))
    else $error("apply ran over an occupied result register");

  a_result_len: assert property (@(posedge clk) disable iff (!rst_n)
    apply_en |=> out_valid && out_length_now == len_r && out_cursor_now == cur_r)
    else $error("result disagrees with state");

endmodule
`default_nettype wire

FILE: sim/tb_cursor_list_buffer.sv
// Self-checking testbench for cursor_list_buffer: directed and random requests.
module tb_cursor_list_buffer;

  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum { GROW, SHRINK, MIXED } phase_bias_t;

  typedef struct packed {
    logic [2:0]                       status;
    logic signed [31:0]               rd;
    logic signed [clb_pkg::CUR_W-1:0] cur;
    logic [clb_pkg::LEN_W-1:0]        len;
  } list_reply_t;

  // Tracks the list contents and cursor; holds the replies still owed.
  class list_scoreboard;
    logic signed [31:0] cells [clb_pkg::DEPTH];
    int len;
    int cur;
    int errors;
    list_reply_t expected_replies [$];

    function new();
      len = 0;
      cur = 0;
      errors = 0;
    endfunction

    function void open_gap(int at, logic signed [31:0] word);
      for (int k = len; k > at; k--) cells[k] = cells[k-1];
      cells[at] = word;
      len++;
    endfunction

    function void close_gap(int at);
      for (int k = at; k + 1 < len; k++) cells[k] = cells[k+1];
      len--;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function void note_request(logic [3:0] op, logic [15:0] position,
                               logic signed [31:0] word);
      list_reply_t r;
      int p;
      bit cur_in;
      logic signed [31:0] t;
      p = int'(position);
      cur_in = (cur >= 0) && (cur < len);
      r.status = clb_pkg::STAT_OK;
      r.rd = '0;
      case (op)
        clb_pkg::OP_APPEND: begin
          if (len >= clb_pkg::DEPTH) r.status = clb_pkg::STAT_FULL;
          else open_gap(len, word);
        end
        clb_pkg::OP_INSERT_AT: begin
          if (len >= clb_pkg::DEPTH) r.status = clb_pkg::STAT_FULL;
          else if (p > len) r.status = clb_pkg::STAT_OOB;
          else open_gap(p, word);
        end
        clb_pkg::OP_DELETE_LAST: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else len--;
        end
        clb_pkg::OP_DELETE_AT: begin
          if (p >= len) r.status = clb_pkg::STAT_OOB;
          else close_gap(p);
        end
        clb_pkg::OP_FWD: begin
          if (len == 0) begin
            r.status = clb_pkg::STAT_EMPTY;
            cur = -1;
          end else begin
            cur = (p < len - 1) ? p : len - 1;
          end
        end
        clb_pkg::OP_BACK: begin
          if (len == 0) begin
            r.status = clb_pkg::STAT_EMPTY;
            cur = -1;
          end else if (p > len) begin
            r.status = clb_pkg::STAT_OOB;
            cur = -1;
          end else begin
            cur = len - p;
          end
        end
        clb_pkg::OP_INS_CUR: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (cur < 0 || cur > len) r.status = clb_pkg::STAT_OOB;
          else if (len >= clb_pkg::DEPTH) r.status = clb_pkg::STAT_FULL;
          else open_gap(cur, word);
        end
        clb_pkg::OP_DEL_CUR: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (!cur_in) r.status = clb_pkg::STAT_OOB;
          else close_gap(cur);
        end
        clb_pkg::OP_READ_CUR: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (!cur_in) r.status = clb_pkg::STAT_OOB;
          else r.rd = cells[cur];
        end
        clb_pkg::OP_UPD_AT: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (p >= len) r.status = clb_pkg::STAT_OOB;
          else cells[p] = word;
        end
        clb_pkg::OP_UPD_CUR: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (cur < 0) r.status = clb_pkg::STAT_NULL;
          else if (!cur_in) r.status = clb_pkg::STAT_OOB;
          else cells[cur] = word;
        end
        clb_pkg::OP_SWAP: begin
          if (len == 0) r.status = clb_pkg::STAT_EMPTY;
          else if (!cur_in || p >= len) r.status = clb_pkg::STAT_OOB;
          else begin
            t = cells[cur];
            cells[cur] = cells[p];
            cells[p] = t;
          end
        end
        default: ;
      endcase
      r.cur = cur[clb_pkg::CUR_W-1:0];
      r.len = len[clb_pkg::LEN_W-1:0];
      expected_replies.push_back(r);
    endfunction

    function void field_check(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_reply(list_reply_t act);
      list_reply_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result item, status %0d cursor %0d length %0d",
                 $time, act.status, act.cur, act.len);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      field_check("status", longint'(e.status), longint'(act.status));
      field_check("read_value", longint'(e.rd), longint'(act.rd));
      field_check("cursor_now", longint'(e.cur), longint'(act.cur));
      field_check("length_now", longint'(e.len), longint'(act.len));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_op = '0;
  logic [15:0]        in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [2:0]         out_status;
  logic signed [31:0] out_read_value;
  logic signed [7:0]  out_cursor_now;
  logic [6:0]         out_length_now;

  list_scoreboard sb = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  cursor_list_buffer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_cursor_now (out_cursor_now),
    .out_length_now (out_length_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function int idle_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [3:0] pick_op(phase_bias_t bias);
    int r;
    r = $urandom_range(0, 99);
    case (bias)
      GROW: begin
        if (r < 40) return clb_pkg::OP_APPEND;
        if (r < 60) return clb_pkg::OP_INSERT_AT;
        if (r < 68) return clb_pkg::OP_INS_CUR;
        return 4'($urandom_range(0, 15));
      end
      SHRINK: begin
        if (r < 25) return clb_pkg::OP_DELETE_LAST;
        if (r < 45) return clb_pkg::OP_DELETE_AT;
        if (r < 60) return clb_pkg::OP_DEL_CUR;
        return 4'($urandom_range(0, 15));
      end
      default: begin
        if (r < 4) return 4'($urandom_range(12, 15));
        return 4'($urandom_range(0, 11));
      end
    endcase
  endfunction

  // Positions mostly near the current length so edits land in range.
  function logic [15:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom_range(0, 65535));
    if (r < 11) return 16'hFFFF;
    return 16'($urandom_range(0, sb.len + 1));
  endfunction

  function logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh7FFFFFFF;
    if (r < 6) return 32'sh80000000;
    if (r < 8) return '0;
    if (r < 10) return -32'sd1;
    return $urandom;
  endfunction

  task send_request(logic [3:0] op, logic [15:0] position, logic signed [31:0] word);
    int gap;
    gap = idle_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= position;
    in_value    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, position, word);
  endtask

  // Result side: check on handshake, then pick the next stall.
  initial begin
    int hold;
    int cycles;
    list_reply_t act;
    hold = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        act.status = out_status;
        act.rd     = out_read_value;
        act.cur    = out_cursor_now;
        act.len    = out_length_now;
        sb.check_reply(act);
      end
      cycles++;
      if (cycles % 150 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (hold > 0) hold--;
      else hold = idle_gap(rx_quiet);
      out_ready <= (hold == 0);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sent;
    int n;
    phase_bias_t bias;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every op on an empty list, then cursor corner cases on a short one.
    send_request(clb_pkg::OP_READ_CUR, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_DEL_CUR, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_UPD_CUR, 16'd0, 32'sd9);
    send_request(clb_pkg::OP_SWAP, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_DELETE_LAST, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_DELETE_AT, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_UPD_AT, 16'd0, 32'sd1);
    send_request(clb_pkg::OP_INS_CUR, 16'd0, 32'sd2);
    send_request(clb_pkg::OP_INSERT_AT, 16'd1, 32'sd3);
    send_request(clb_pkg::OP_FWD, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_BACK, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_APPEND, 16'hFFFF, 32'sh7FFFFFFF);
    send_request(clb_pkg::OP_UPD_CUR, 16'd0, 32'sd4);       // cursor points nowhere
    send_request(clb_pkg::OP_INS_CUR, 16'd0, 32'sd5);
    send_request(clb_pkg::OP_INSERT_AT, 16'd0, 32'sh80000000);
    send_request(clb_pkg::OP_APPEND, 16'd0, -32'sd1);
    send_request(clb_pkg::OP_FWD, 16'hFFFF, 32'sd0);        // clamps to last
    send_request(clb_pkg::OP_READ_CUR, 16'd0, 32'sd0);
    send_request(clb_pkg::OP_BACK, 16'd0, 32'sd0);          // one past the end
    send_request(clb_pkg::OP_INS_CUR, 16'd0, 32'sd0);       // acts as append
    send_request(clb_pkg::OP_BACK, 16'hFFFF, 32'sd0);
    send_request(clb_pkg::OP_BACK, 16'd4, 32'sd0);
    send_request(clb_pkg::OP_SWAP, 16'd3, 32'sd0);
    send_request(clb_pkg::OP_UPD_AT, 16'd1, 32'sh55AA55AA);
    send_request(clb_pkg::OP_DEL_CUR, 16'd0, 32'sd0);
    send_request(4'd12, 16'hFFFF, -32'sd1);
    send_request(4'd15, 16'd0, 32'sd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: bias = GROW;
        1: bias = SHRINK;
        default: bias = MIXED;
      endcase
      n = $urandom_range(40, 160);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        send_request(pick_op(bias), pick_position(), pick_word());
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d result items never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
